/* src/rfcd_pkg.sv */
// shared types, constants and the crc byte step for the remote frame decoder
package rfcd_pkg;

  localparam logic [7:0]  HDR0          = 8'hA9;
  localparam logic [7:0]  HDR1          = 8'h53;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'h8408;
  localparam int          NUM_STORED    = 18;
  localparam logic [4:0]  STORE_FIRST   = 5'd2;
  localparam logic [4:0]  STORE_LAST    = 5'd19;
  localparam logic [4:0]  CRC_LAST_IDX  = 5'd18;
  localparam logic [4:0]  LAST_IDX      = 5'd20;
  localparam int          OUT_DATA_W    = 128;

  typedef enum logic [1:0] {
    ST_GOOD    = 2'd0,
    ST_HDR_BAD = 2'd1,
    ST_CRC_BAD = 2'd2
  } status_t;

  // one input word as held by the input register
  typedef struct packed {
    logic       start;
    logic [7:0] data;
  } item_t;

  // decoded frame result
  typedef struct packed {
    status_t            status;
    logic [10:0]        stick_0;
    logic [10:0]        stick_1;
    logic [10:0]        stick_2;
    logic [10:0]        stick_3;
    logic [10:0]        dial_value;
    logic [5:0]         button_group;
    logic signed [15:0] mouse_dx;
    logic signed [15:0] mouse_dy;
    logic signed [15:0] mouse_wheel;
    logic [2:0]         mouse_buttons;
    logic [15:0]        key_mask;
  } result_t;

  // reflected crc-16, one byte, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* src/remote_frame_crc_decoder_top.sv */
// top level of the fixed-frame remote-control decoder with crc-16 check
// throughput: one byte word per cycle; while a result waits on out_tready every word stalls
// a byte word is held in the input register until the core takes it; the result of a frame
// is loaded into the output register as its last byte is taken, and then shows on out_tvalid
// rate is set by the combinational crc byte step between input and output registers
// reset (rst_n low, synchronous) empties both registers and closes any open frame
module remote_frame_crc_decoder_top
  import rfcd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // rx_byte [7:0]
  input  logic                  in_tuser,   // frame_start
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // stick_0 [10:0], stick_1 [21:11], stick_2 [32:22], stick_3 [43:33],
  // dial_value [54:44], button_group [60:55], mouse_dx [76:61], mouse_dy [92:77],
  // mouse_wheel [108:93], mouse_buttons [111:109], key_mask [127:112]
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]            out_tuser   // status
);

  item_t   in_item, item;
  logic    item_valid, take, space, res_valid;
  result_t res, out_res;

  assign in_item.start = in_tuser;
  assign in_item.data  = in_tdata;
  assign take          = item_valid && space;

  rfcd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  rfcd_frame_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  rfcd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res       (res),
    .space     (space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tuser = out_res.status;
  assign out_tdata = {out_res.key_mask, out_res.mouse_buttons, out_res.mouse_wheel,
                      out_res.mouse_dy, out_res.mouse_dx, out_res.button_group,
                      out_res.dial_value, out_res.stick_3, out_res.stick_2,
                      out_res.stick_1, out_res.stick_0};

endmodule

/* src/rfcd_in_stage.sv */
// input register stage holding one received word
module rfcd_in_stage
  import rfcd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  take,
  output logic  item_valid,
  output item_t item
);

  logic  v_r, v_nxt;
  item_t item_r;

  assign in_ready   = !v_r || take;
  assign item_valid = v_r;
  assign item       = item_r;

  always_comb begin
    v_nxt = v_r;
    if (in_valid && in_ready) begin
      v_nxt = 1'b1;
    end else if (take) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

/* src/rfcd_frame_core.sv */
// frame tracking, header and crc check, byte store and field decode
module rfcd_frame_core
  import rfcd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    take,
  input  item_t   item,
  output logic    res_valid,
  output result_t res
);

  logic [4:0]  byte_index_r, byte_index_nxt;
  logic        in_frame_r, in_frame_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        hdr_good_r, hdr_good_nxt;
  logic [7:0]  bytes_r [NUM_STORED];

  logic        active;
  logic [4:0]  idx;
  logic [4:0]  wr_addr;
  logic        wr_en;
  logic [63:0] packed_f;
  status_t     status;

  assign active  = take && (item.start || in_frame_r);
  assign idx     = item.start ? 5'd0 : byte_index_r;
  assign wr_addr = idx - STORE_FIRST;
  assign wr_en   = active && (idx >= STORE_FIRST) && (idx <= STORE_LAST);

  always_comb begin
    byte_index_nxt = byte_index_r;
    in_frame_nxt   = in_frame_r;
    crc_nxt        = crc_r;
    hdr_good_nxt   = hdr_good_r;
    if (active) begin
      if (idx == 5'd0) begin
        hdr_good_nxt = (item.data == HDR0);
      end else if (idx == 5'd1) begin
        hdr_good_nxt = hdr_good_r && (item.data == HDR1);
      end
      if (idx <= CRC_LAST_IDX) begin
        crc_nxt = crc_byte(item.start ? CRC_INIT : crc_r, item.data);
      end
      if (idx < LAST_IDX) begin
        byte_index_nxt = idx + 5'd1;
        in_frame_nxt   = 1'b1;
      end else begin
        byte_index_nxt = 5'd0;
        in_frame_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r <= 5'd0;
      in_frame_r   <= 1'b0;
      crc_r        <= CRC_INIT;
      hdr_good_r   <= 1'b0;
    end else begin
      byte_index_r <= byte_index_nxt;
      in_frame_r   <= in_frame_nxt;
      crc_r        <= crc_nxt;
      hdr_good_r   <= hdr_good_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bytes_r[wr_addr] <= item.data;
    end
  end

  // on the last byte, byte 19 already sits in the store and crc is final
  assign res_valid = active && (idx == LAST_IDX);

  always_comb begin
    if (!hdr_good_r) begin
      status = ST_HDR_BAD;
    end else if ((crc_r[7:0] != bytes_r[17]) || (crc_r[15:8] != item.data)) begin
      status = ST_CRC_BAD;
    end else begin
      status = ST_GOOD;
    end
  end

  assign packed_f = {bytes_r[7], bytes_r[6], bytes_r[5], bytes_r[4],
                     bytes_r[3], bytes_r[2], bytes_r[1], bytes_r[0]};

  always_comb begin
    res        = '0;
    res.status = status;
    if (status == ST_GOOD) begin
      res.stick_0       = packed_f[10:0];
      res.stick_1       = packed_f[21:11];
      res.stick_2       = packed_f[32:22];
      res.stick_3       = packed_f[43:33];
      res.dial_value    = packed_f[59:49];
      res.button_group  = {packed_f[60], packed_f[48:44]};
      res.mouse_dx      = {bytes_r[9], bytes_r[8]};
      res.mouse_dy      = {bytes_r[11], bytes_r[10]};
      res.mouse_wheel   = {bytes_r[13], bytes_r[12]};
      res.mouse_buttons = {bytes_r[14][4], bytes_r[14][2], bytes_r[14][0]};
      res.key_mask      = {bytes_r[16], bytes_r[15]};
    end
  end

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_index_r <= LAST_IDX)
    else $error("byte index past end of frame");

  a_idle_index: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> byte_index_r == 5'd0)
    else $error("byte index nonzero outside a frame");

  a_result_closes: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !item.start |=> !in_frame_r)
    else $error("frame still open after its result");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.status != ST_GOOD |->
      res.key_mask == 16'd0 && res.mouse_dx == 16'sd0 && res.stick_0 == 11'd0)
    else $error("data fields not cleared on failed frame");

endmodule

/* src/rfcd_out_stage.sv */
// output register holding one decoded result word
module rfcd_out_stage
  import rfcd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res,
  output logic    space,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    ov_r, ov_nxt;
  result_t res_r;

  assign space     = !ov_r || out_ready;
  assign out_valid = ov_r;
  assign out_res   = res_r;

  always_comb begin
    ov_nxt = ov_r;
    if (load) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

/* test/tb.sv */
// testbench for the remote frame decoder: crc-checked frames, errors, restarts, back pressure
module tb
  import rfcd_pkg::*;
();

  localparam int CYCLE_LIMIT  = 500000;
  localparam int ITEM_TARGET  = 1500;
  localparam int FRAME_BYTES  = 21;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 20;

  typedef enum int {
    FRM_GOOD,
    FRM_HDR0_BAD,
    FRM_HDR1_BAD,
    FRM_HDR_CRC_BAD,
    FRM_CRC_LO_BAD,
    FRM_CRC_HI_BAD,
    FRM_BODY_BAD
  } frame_kind_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;   // rx_byte [7:0]
  logic         in_tuser;   // frame_start
  logic         out_tvalid;
  logic         out_tready;
  // stick_0 [10:0], stick_1 [21:11], stick_2 [32:22], stick_3 [43:33],
  // dial_value [54:44], button_group [60:55], mouse_dx [76:61], mouse_dy [92:77],
  // mouse_wheel [108:93], mouse_buttons [111:109], key_mask [127:112]
  logic [127:0] out_tdata;
  logic [1:0]   out_tuser;  // status

  remote_frame_crc_decoder_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // decoder shadow state
  logic [4:0]  dec_pos;
  logic        dec_open;
  logic [15:0] dec_crc;
  logic        dec_hdr_ok;
  logic [7:0]  dec_store [NUM_STORED];

  result_t     frame_results [$];
  logic [7:0]  frame_buf [FRAME_BYTES];
  int          err_count;
  int          items_sent;
  int          cycle_count;
  int          hold_cycles;
  bit          steady;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] a;
    logic        fb;
    a = acc;
    for (int i = 0; i < 8; i++) begin
      fb = a[0] ^ d[i];
      a  = a >> 1;
      if (fb) begin
        a = a ^ CRC_POLY;
      end
    end
    return a;
  endfunction

  // advance the shadow decoder by one accepted word
  function automatic void decode_byte(input logic [7:0] b, input logic start);
    result_t     r;
    logic [63:0] pk;
    if (start) begin
      dec_open = 1'b1;
      dec_pos  = '0;
      dec_crc  = CRC_INIT;
    end else if (!dec_open) begin
      return;
    end
    if (dec_pos == 5'd0) begin
      dec_hdr_ok = (b == HDR0);
    end else if (dec_pos == 5'd1) begin
      dec_hdr_ok = dec_hdr_ok && (b == HDR1);
    end
    if (dec_pos >= STORE_FIRST && dec_pos <= STORE_LAST) begin
      dec_store[dec_pos - STORE_FIRST] = b;
    end
    if (dec_pos <= CRC_LAST_IDX) begin
      dec_crc = crc16_update(dec_crc, b);
    end
    if (dec_pos < LAST_IDX) begin
      dec_pos = dec_pos + 5'd1;
      return;
    end
    dec_open = 1'b0;
    dec_pos  = '0;
    r = '0;
    if (!dec_hdr_ok) begin
      r.status = ST_HDR_BAD;
    end else if (dec_crc != {b, dec_store[17]}) begin
      r.status = ST_CRC_BAD;
    end else begin
      r.status = ST_GOOD;
      for (int k = 0; k < 8; k++) begin
        pk[8*k +: 8] = dec_store[k];
      end
      r.stick_0       = pk[10:0];
      r.stick_1       = pk[21:11];
      r.stick_2       = pk[32:22];
      r.stick_3       = pk[43:33];
      r.dial_value    = pk[59:49];
      r.button_group  = {pk[60], pk[48:44]};
      r.mouse_dx      = {dec_store[9], dec_store[8]};
      r.mouse_dy      = {dec_store[11], dec_store[10]};
      r.mouse_wheel   = {dec_store[13], dec_store[12]};
      r.mouse_buttons = {dec_store[14][4], dec_store[14][2], dec_store[14][0]};
      r.key_mask      = {dec_store[16], dec_store[15]};
    end
    frame_results.push_back(r);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 70) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic start);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_byte(b, start);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // body bytes 2..18; random bodies lean toward the all-zero and all-one values
  task automatic fill_body(input logic [7:0] fill, input bit randomize_body);
    for (int i = 2; i <= CRC_LAST_IDX; i++) begin
      if (!randomize_body) begin
        frame_buf[i] = fill;
      end else begin
        case ($urandom_range(0, 9))
          0: frame_buf[i] = 8'h00;
          1: frame_buf[i] = 8'hFF;
          default: frame_buf[i] = 8'($urandom_range(0, 255));
        endcase
      end
    end
  endtask

  task automatic seal_frame(input frame_kind_t kind);
    logic [15:0] acc;
    frame_buf[0] = HDR0;
    frame_buf[1] = HDR1;
    if (kind == FRM_HDR0_BAD) begin
      frame_buf[0] ^= 8'($urandom_range(1, 255));
    end
    if (kind == FRM_HDR1_BAD) begin
      frame_buf[1] ^= 8'($urandom_range(1, 255));
    end
    acc = CRC_INIT;
    for (int i = 0; i <= CRC_LAST_IDX; i++) begin
      acc = crc16_update(acc, frame_buf[i]);
    end
    frame_buf[19] = acc[7:0];
    frame_buf[20] = acc[15:8];
    case (kind)
      FRM_HDR_CRC_BAD: begin
        frame_buf[0]  ^= 8'($urandom_range(1, 255));
        frame_buf[19] ^= 8'($urandom_range(1, 255));
      end
      FRM_CRC_LO_BAD: frame_buf[19] ^= 8'($urandom_range(1, 255));
      FRM_CRC_HI_BAD: frame_buf[20] ^= 8'($urandom_range(1, 255));
      FRM_BODY_BAD:   frame_buf[$urandom_range(2, 18)] ^= 8'($urandom_range(1, 255));
      default: ;
    endcase
  endtask

  task automatic send_frame(input int n_bytes);
    for (int i = 0; i < n_bytes; i++) begin
      send_byte(frame_buf[i], i == 0);
      items_sent++;
    end
  endtask

  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++) begin
      send_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  task automatic test_outside_frame();
    send_byte(HDR0, 1'b0);
    send_byte(HDR1, 1'b0);
    send_noise(2);
  endtask

  task automatic test_good_extremes();
    fill_body(8'h00, 1'b0);
    seal_frame(FRM_GOOD);
    send_frame(FRAME_BYTES);
    fill_body(8'hFF, 1'b0);
    seal_frame(FRM_GOOD);
    send_frame(FRAME_BYTES);
    // a stray word between frames must be dropped
    send_noise(1);
    fill_body(8'h55, 1'b0);
    seal_frame(FRM_GOOD);
    send_frame(FRAME_BYTES);
  endtask

  task automatic test_header_errors();
    fill_body(8'h00, 1'b1);
    seal_frame(FRM_HDR0_BAD);
    send_frame(FRAME_BYTES);
    fill_body(8'h00, 1'b1);
    seal_frame(FRM_HDR1_BAD);
    send_frame(FRAME_BYTES);
    // header wins over checksum
    fill_body(8'h00, 1'b1);
    seal_frame(FRM_HDR_CRC_BAD);
    send_frame(FRAME_BYTES);
  endtask

  task automatic test_crc_errors();
    fill_body(8'h00, 1'b1);
    seal_frame(FRM_CRC_LO_BAD);
    send_frame(FRAME_BYTES);
    fill_body(8'h00, 1'b1);
    seal_frame(FRM_CRC_HI_BAD);
    send_frame(FRAME_BYTES);
  endtask

  task automatic test_restart();
    fill_body(8'h00, 1'b1);
    seal_frame(FRM_GOOD);
    send_frame(7);
    fill_body(8'h00, 1'b1);
    seal_frame(FRM_GOOD);
    send_frame(FRAME_BYTES - 1);
    fill_body(8'h00, 1'b1);
    seal_frame(FRM_GOOD);
    send_frame(FRAME_BYTES);
  endtask

  task automatic test_back_pressure();
    steady      = 1'b1;
    hold_cycles = LONG_HOLD;
    for (int f = 0; f < 16; f++) begin
      fill_body(8'h00, 1'b1);
      seal_frame(FRM_GOOD);
      send_frame(FRAME_BYTES);
    end
    steady = 1'b0;
  endtask

  task automatic test_random_frames();
    int r;
    while (items_sent < ITEM_TARGET) begin
      steady = ($urandom_range(0, 9) == 0);
      r = $urandom_range(0, 99);
      fill_body(8'h00, 1'b1);
      if (r < 60) begin
        seal_frame(FRM_GOOD);
        send_frame(FRAME_BYTES);
      end else if (r < 68) begin
        seal_frame(frame_kind_t'($urandom_range(FRM_CRC_LO_BAD, FRM_BODY_BAD)));
        send_frame(FRAME_BYTES);
      end else if (r < 74) begin
        seal_frame(frame_kind_t'($urandom_range(FRM_HDR0_BAD, FRM_HDR_CRC_BAD)));
        send_frame(FRAME_BYTES);
      end else if (r < 84) begin
        seal_frame(FRM_GOOD);
        send_frame($urandom_range(1, FRAME_BYTES - 1));
      end else if (r < 92) begin
        send_noise($urandom_range(1, 4));
      end else begin
        for (int i = 0; i < FRAME_BYTES; i++) begin
          frame_buf[i] = 8'($urandom_range(0, 255));
        end
        send_frame(FRAME_BYTES);
      end
    end
    steady = 1'b0;
  endtask

  // result side: random stalls, occasional long hold requested by a test
  initial begin
    int n;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        n = hold_cycles;
        hold_cycles = 0;
        repeat (n) @(posedge clk);
      end else if (steady || $urandom_range(0, 99) < 75) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        if ($urandom_range(0, 19) == 0) begin
          repeat ($urandom_range(8, 40)) @(posedge clk);
        end
      end
    end
  end

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (frame_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none actual status %0h data %h",
                 $time, out_tuser, out_tdata);
        err_count++;
      end else begin
        want = frame_results.pop_front();
        check_field("status",        16'(want.status),        16'(out_tuser));
        check_field("stick_0",       16'(want.stick_0),       16'(out_tdata[10:0]));
        check_field("stick_1",       16'(want.stick_1),       16'(out_tdata[21:11]));
        check_field("stick_2",       16'(want.stick_2),       16'(out_tdata[32:22]));
        check_field("stick_3",       16'(want.stick_3),       16'(out_tdata[43:33]));
        check_field("dial_value",    16'(want.dial_value),    16'(out_tdata[54:44]));
        check_field("button_group",  16'(want.button_group),  16'(out_tdata[60:55]));
        check_field("mouse_dx",      want.mouse_dx,           out_tdata[76:61]);
        check_field("mouse_dy",      want.mouse_dy,           out_tdata[92:77]);
        check_field("mouse_wheel",   want.mouse_wheel,        out_tdata[108:93]);
        check_field("mouse_buttons", 16'(want.mouse_buttons), 16'(out_tdata[111:109]));
        check_field("key_mask",      want.key_mask,           out_tdata[127:112]);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    err_count   = 0;
    items_sent  = 0;
    hold_cycles = 0;
    steady      = 1'b0;
    dec_pos     = '0;
    dec_open    = 1'b0;
    dec_crc     = CRC_INIT;
    dec_hdr_ok  = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_outside_frame();
    test_good_extremes();
    test_header_errors();
    test_crc_errors();
    test_restart();
    test_back_pressure();
    test_random_frames();

    in_tvalid <= 1'b0;
    while (frame_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* remote_frame_crc_decoder_top.f */
src/rfcd_pkg.sv
src/rfcd_in_stage.sv
src/rfcd_frame_core.sv
src/rfcd_out_stage.sv
src/remote_frame_crc_decoder_top.sv
test/tb.sv
